[hw/rtl/lskr_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the LIFO stack.
`timescale 1ns / 1ps

package lskr_pkg;

  localparam int DEPTH   = 64;
  localparam int AW      = $clog2(DEPTH);
  localparam int COUNT_W = 7;
  localparam int ID_W    = 32;
  localparam int PAY_W   = 64;
  localparam int CMD_W   = 3;
  localparam int ST_W    = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_NOKEY = 2'd3;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_TOP,
    PTR_DEC,
    PTR_INC
  } ptr_op_t;

  typedef enum logic [1:0] {
    FILL_HOLD,
    FILL_INC,
    FILL_DEC
  } fill_op_t;

  typedef enum logic [2:0] {
    SRC_INPUT,
    SRC_ZERO,
    SRC_KEY,
    SRC_RDATA,
    SRC_HIT
  } out_src_t;

  typedef enum logic {
    WR_PUSH,
    WR_SHIFT
  } wr_src_t;

  typedef struct packed {
    logic            load;
    logic            rd_en;
    ptr_op_t         ptr_op;
    logic            wr_en;
    wr_src_t         wr_src;
    fill_op_t        fill_op;
    logic            id_adv;
    logic            hit_load;
    logic            emit;
    out_src_t        src;
    logic [ST_W-1:0] status;
    logic            last;
  } lskr_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             fill_zero;
    logic             full;
    logic             ptr_zero;
    logic             key_match;
    logic             shift_more;
    logic             out_free;
  } lskr_sts_t;

endpackage

[hw/rtl/lifo_stack_with_keyed_removal_core.sv]
// Top level of the LIFO stack with removal by id: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries one command transaction: cmd,
//   payload and key_id. Output channel (out_valid/out_ready) carries result
//   transactions: status, entry_id, entry_payload, count and last.
//   Push, pop, peek and remove give one result with last set; list gives one
//   per held entry, top to base, last on the base entry; unused codes 5 to 7
//   give none. Steps after acceptance: push and the empty-stack cases register
//   the result in the decode state; pop and peek read the top entry there and
//   register it in the top state; list reads the top entry, then registers each
//   entry in the list state while reading the one below; remove reads the top,
//   scans down to the matching id, moves the entries above it one place down
//   and registers the removed entry, or the key if no id matches.
//   The entry memory has one read and one write port; the scan and the shift
//   each walk it one entry per cycle. One command is worked at a time: in_ready
//   is high from the edge that registers the final result, even while that
//   result still waits, so a new transaction can be taken before it drains.
//   While a result waits with out_ready low, a step that issues a result holds,
//   read data in place, until the output register frees.
//   Reset (rst, synchronous) empties the stack, sets the next id to 1 and
//   drops any pending result; memory is not cleared, only held slots are read.

module lifo_stack_with_keyed_removal_core import lskr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [PAY_W-1:0]   payload,
  input  logic [ID_W-1:0]    key_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ST_W-1:0]    status,
  output logic [ID_W-1:0]    entry_id,
  output logic [PAY_W-1:0]   entry_payload,
  output logic [COUNT_W-1:0] count,
  output logic               last
);

  // Commands from the sequencer, flags back from the datapath.
  lskr_ctl_t ctl;
  lskr_sts_t sts;

  lskr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  lskr_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .cmd           (cmd),
    .payload       (payload),
    .key_id        (key_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .entry_id      (entry_id),
    .entry_payload (entry_payload),
    .count         (count),
    .last          (last)
  );

endmodule

[hw/rtl/lskr_ctrl.sv]
// Sequencing state machine for the LIFO stack commands.
`timescale 1ns / 1ps

module lskr_ctrl import lskr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lskr_sts_t sts,
  output lskr_ctl_t ctl
);

  typedef enum logic [7:0] {
    S_IDLE        = 8'b0000_0001,
    S_DECODE      = 8'b0000_0010,
    S_TOP         = 8'b0000_0100,
    S_SCAN        = 8'b0000_1000,
    S_SHIFT       = 8'b0001_0000,
    S_REMOVE_DONE = 8'b0010_0000,
    S_NOKEY       = 8'b0100_0000,
    S_LIST        = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    ctl.load     = 1'b0;
    ctl.rd_en    = 1'b0;
    ctl.ptr_op   = PTR_HOLD;
    ctl.wr_en    = 1'b0;
    ctl.wr_src   = WR_PUSH;
    ctl.fill_op  = FILL_HOLD;
    ctl.id_adv   = 1'b0;
    ctl.hit_load = 1'b0;
    ctl.emit     = 1'b0;
    ctl.src      = SRC_ZERO;
    ctl.status   = ST_OK;
    ctl.last     = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          CMD_PUSH: begin
            if (sts.out_free) begin
              ctl.emit   = 1'b1;
              ctl.src    = SRC_INPUT;
              ctl.id_adv = 1'b1;
              if (sts.full) begin
                ctl.status = ST_FULL;
              end else begin
                ctl.wr_en   = 1'b1;
                ctl.wr_src  = WR_PUSH;
                ctl.fill_op = FILL_INC;
              end
              state_next = S_IDLE;
            end
          end
          CMD_POP, CMD_PEEK, CMD_REMOVE, CMD_LIST: begin
            if (sts.fill_zero) begin
              if (sts.out_free) begin
                ctl.emit   = 1'b1;
                ctl.src    = SRC_ZERO;
                ctl.status = ST_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              ctl.ptr_op = PTR_TOP;
              ctl.rd_en  = 1'b1;
              if (sts.op == CMD_REMOVE) begin
                state_next = S_SCAN;
              end else if (sts.op == CMD_LIST) begin
                state_next = S_LIST;
              end else begin
                state_next = S_TOP;
              end
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_TOP: begin
        if (sts.out_free) begin
          ctl.emit = 1'b1;
          ctl.src  = SRC_RDATA;
          if (sts.op == CMD_POP) begin
            ctl.fill_op = FILL_DEC;
          end
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.key_match) begin
          ctl.hit_load = 1'b1;
          if (sts.shift_more) begin
            ctl.ptr_op = PTR_INC;
            ctl.rd_en  = 1'b1;
            state_next = S_SHIFT;
          end else begin
            state_next = S_REMOVE_DONE;
          end
        end else if (sts.ptr_zero) begin
          state_next = S_NOKEY;
        end else begin
          ctl.ptr_op = PTR_DEC;
          ctl.rd_en  = 1'b1;
        end
      end
      S_SHIFT: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_src = WR_SHIFT;
        if (sts.shift_more) begin
          ctl.ptr_op = PTR_INC;
          ctl.rd_en  = 1'b1;
        end else begin
          state_next = S_REMOVE_DONE;
        end
      end
      S_REMOVE_DONE: begin
        if (sts.out_free) begin
          ctl.emit    = 1'b1;
          ctl.src     = SRC_HIT;
          ctl.fill_op = FILL_DEC;
          state_next  = S_IDLE;
        end
      end
      S_NOKEY: begin
        if (sts.out_free) begin
          ctl.emit   = 1'b1;
          ctl.src    = SRC_KEY;
          ctl.status = ST_NOKEY;
          state_next = S_IDLE;
        end
      end
      S_LIST: begin
        if (sts.out_free) begin
          ctl.emit = 1'b1;
          ctl.src  = SRC_RDATA;
          ctl.last = sts.ptr_zero;
          if (sts.ptr_zero) begin
            state_next = S_IDLE;
          end else begin
            ctl.ptr_op = PTR_DEC;
            ctl.rd_en  = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> sts.out_free)
    else $error("result issued while output register is occupied");

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DECODE)
    else $error("accepted transaction not decoded");

  a_shift_has_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> $past(ctl.hit_load) || $past(state == S_SHIFT))
    else $error("shift entered without a key match");

endmodule

[hw/rtl/lskr_dpath.sv]
// Entry memory, fill and id counters, and output register for the LIFO stack.
`timescale 1ns / 1ps

module lskr_dpath import lskr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  lskr_ctl_t          ctl,
  output lskr_sts_t          sts,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [PAY_W-1:0]   payload,
  input  logic [ID_W-1:0]    key_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ST_W-1:0]    status,
  output logic [ID_W-1:0]    entry_id,
  output logic [PAY_W-1:0]   entry_payload,
  output logic [COUNT_W-1:0] count,
  output logic               last
);

  localparam int ENT_W = ID_W + PAY_W;

  logic [ENT_W-1:0]   mem [DEPTH];
  logic [ENT_W-1:0]   rdata;
  logic [ENT_W-1:0]   hit;
  logic [CMD_W-1:0]   op;
  logic [PAY_W-1:0]   pay_reg;
  logic [ID_W-1:0]    key_reg;
  logic [COUNT_W-1:0] fill, fill_next;
  logic [ID_W-1:0]    next_id, next_id_next;
  logic [AW-1:0]      ptr, ptr_next;
  logic [AW-1:0]      waddr;
  logic [ENT_W-1:0]   wdata;
  logic [ID_W-1:0]    o_id;
  logic [PAY_W-1:0]   o_pay;

  assign next_id_next = (next_id == '1) ? ID_W'(1) : next_id + ID_W'(1);

  always_comb begin
    case (ctl.fill_op)
      FILL_INC: fill_next = fill + COUNT_W'(1);
      FILL_DEC: fill_next = fill - COUNT_W'(1);
      default:  fill_next = fill;
    endcase
  end

  always_comb begin
    case (ctl.ptr_op)
      PTR_TOP: ptr_next = AW'(fill - COUNT_W'(1));
      PTR_DEC: ptr_next = ptr - AW'(1);
      PTR_INC: ptr_next = ptr + AW'(1);
      default: ptr_next = ptr;
    endcase
  end

  // Push lands at the fill slot; a shift moves the entry just read one place down.
  always_comb begin
    if (ctl.wr_src == WR_PUSH) begin
      waddr = AW'(fill);
      wdata = {next_id, pay_reg};
    end else begin
      waddr = ptr - AW'(1);
      wdata = rdata;
    end
  end

  always_comb begin
    case (ctl.src)
      SRC_INPUT: begin
        o_id  = next_id;
        o_pay = pay_reg;
      end
      SRC_KEY: begin
        o_id  = key_reg;
        o_pay = '0;
      end
      SRC_RDATA: begin
        o_id  = rdata[ENT_W-1:PAY_W];
        o_pay = rdata[PAY_W-1:0];
      end
      SRC_HIT: begin
        o_id  = hit[ENT_W-1:PAY_W];
        o_pay = hit[PAY_W-1:0];
      end
      default: begin
        o_id  = '0;
        o_pay = '0;
      end
    endcase
  end

  assign sts.op         = op;
  assign sts.fill_zero  = (fill == '0);
  assign sts.full       = (fill == COUNT_W'(DEPTH));
  assign sts.ptr_zero   = (ptr == '0);
  assign sts.key_match  = (rdata[ENT_W-1:PAY_W] == key_reg);
  assign sts.shift_more = ((COUNT_W'(ptr) + COUNT_W'(1)) < fill);
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      next_id   <= ID_W'(1);
      out_valid <= 1'b0;
    end else begin
      fill <= fill_next;
      if (ctl.id_adv) begin
        next_id <= next_id_next;
      end
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (ctl.load) begin
      op      <= cmd;
      pay_reg <= payload;
      key_reg <= key_id;
    end
    if (ctl.hit_load) begin
      hit <= rdata;
    end
    if (ctl.emit) begin
      status        <= ctl.status;
      entry_id      <= o_id;
      entry_payload <= o_pay;
      count         <= fill_next;
      last          <= ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[ptr_next];
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= COUNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    ctl.fill_op == FILL_INC |-> !sts.full && ctl.wr_en)
    else $error("entry stored into a full stack");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> out_valid && count == $past(fill_next))
    else $error("issued result not presented");

endmodule
